/* rtl/hpt_pkg.sv */
// shared types and constants for the homogeneous point transform
// used by every module under rtl; depends on nothing else
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int ACC_W         = 64;
  localparam int REG_W         = 64;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 4;
  // quotient bits kept by the divider: 32 result bits plus one for the clamp decision
  localparam int Q_BITS        = 33;

  localparam logic [0:0] ACT_POINT  = 1'b0;
  localparam logic [0:0] ACT_VECTOR = 1'b1;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic                      w_was_zero;
    logic                      saturated;
  } result_t;

  // m[r][c], each entry signed fixed point
  typedef logic [3:0][3:0][COORD_W-1:0] mat_t;
  // row sums x, y, z, w
  typedef logic [3:0][ACC_W-1:0] sums_t;

  // sideband that rides with each divider lane
  typedef struct packed {
    logic               wzero;
    logic               use_div;
    logic               byp_sat;
    logic [COORD_W-1:0] byp_val;
  } div_tag_t;

endpackage

/* rtl/hpt_mac.sv */
// matrix by coordinate product: multiply stage and two adder stages
// depends on hpt_pkg
`timescale 1ns / 1ps
module hpt_mac import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  input  mat_t  mat,
  output logic  out_valid,
  output logic  out_vec,
  output sums_t out_sums
);

  logic signed [ACC_W-1:0] prod [4][3];
  logic signed [ACC_W-1:0] part_a [4];
  logic signed [ACC_W-1:0] part_b [4];
  logic signed [ACC_W-1:0] trans [4];
  logic                    v1, v2, vec1, vec2;
  logic signed [COORD_W-1:0] coord [3];

  assign coord[0] = in_item.x_in;
  assign coord[1] = in_item.y_in;
  assign coord[2] = in_item.z_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    vec1 <= in_item.action;
    vec2 <= vec1;
    out_vec <= vec2;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] <= ACC_W'($signed(mat[r][c])) * ACC_W'(coord[c]);
      end
      // floor shifts of the products
      part_a[r] <= (prod[r][0] >>> FRAC_BITS) + (prod[r][1] >>> FRAC_BITS);
      part_b[r] <= prod[r][2] >>> FRAC_BITS;
      trans[r]  <= (vec1 == ACT_VECTOR) ? '0 : ACC_W'($signed(mat[r][3]));
      out_sums[r] <= part_a[r] + part_b[r] + trans[r];
    end
  end

endmodule

/* rtl/hpt_div.sv */
// pipelined restoring divider, one quotient bit per stage: (num << FRAC_BITS) / den
// depends on hpt_pkg
`timescale 1ns / 1ps
module hpt_div import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_neg,
  input  logic [ACC_W-1:0]   in_num,
  input  logic [ACC_W-1:0]   in_den,
  input  div_tag_t           in_tag,
  output logic               out_valid,
  output logic               out_neg,
  output logic               out_ovf,
  output logic [Q_BITS-1:0]  out_q,
  output div_tag_t           out_tag
);

  localparam int NW = ACC_W + FRAC_BITS;
  localparam int RW = NW - Q_BITS;

  logic [NW-1:0]     numer;
  logic [RW-1:0]     rem_init;

  logic              v   [Q_BITS+1];
  logic              neg [Q_BITS+1];
  logic              ovf [Q_BITS+1];
  logic [ACC_W-1:0]  rem [Q_BITS+1];
  logic [ACC_W-1:0]  den [Q_BITS+1];
  logic [Q_BITS-1:0] low [Q_BITS+1];
  logic [Q_BITS-1:0] q   [Q_BITS+1];
  div_tag_t          tag [Q_BITS+1];

  assign numer    = {in_num, {FRAC_BITS{1'b0}}};
  assign rem_init = numer[NW-1:Q_BITS];

  // first stage: a quotient wider than Q_BITS bits is flagged
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    neg[0] <= in_neg;
    ovf[0] <= ACC_W'(rem_init) >= in_den;
    rem[0] <= ACC_W'(rem_init);
    den[0] <= in_den;
    low[0] <= numer[Q_BITS-1:0];
    q[0]   <= '0;
    tag[0] <= in_tag;
  end

  for (genvar i = 1; i <= Q_BITS; i++) begin : g_step
    logic [ACC_W:0] trial;
    logic           fits;

    assign trial = {rem[i-1], low[i-1][Q_BITS-i]};
    assign fits  = trial >= {1'b0, den[i-1]};

    always_ff @(posedge clk) begin
      if (rst) v[i] <= 1'b0;
      else     v[i] <= v[i-1];
    end

    always_ff @(posedge clk) begin
      neg[i] <= neg[i-1];
      ovf[i] <= ovf[i-1];
      den[i] <= den[i-1];
      low[i] <= low[i-1];
      tag[i] <= tag[i-1];
      rem[i] <= fits ? ACC_W'(trial - {1'b0, den[i-1]}) : trial[ACC_W-1:0];
      q[i]   <= q[i-1] | (Q_BITS'(fits) << (Q_BITS - i));
    end
  end

  assign out_valid = v[Q_BITS];
  assign out_neg   = neg[Q_BITS];
  assign out_ovf   = ovf[Q_BITS];
  assign out_q     = q[Q_BITS];
  assign out_tag   = tag[Q_BITS];

endmodule

/* rtl/homogeneous_point_transform.sv */
// top level of the homogeneous point transform: config registers, divide prep, output stage
// depends on hpt_pkg, hpt_mac and hpt_div
`timescale 1ns / 1ps
// Transforms one coordinate by the configured 4x4 matrix per item. A new item is taken
// every clock (busy never rises) and its result appears on result, marked by done, after
// the multiply and add stages, the divide prep register, a 34-stage divider that first
// checks for overflow and then resolves one quotient bit per stage, and one output register.
// Results cannot be held off; the receiver must take done when it comes. Matrix writes
// are meant for idle periods.
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 done,
  output result_t              result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data
);

  localparam int PIPE_DEPTH = 4 + 1 + Q_BITS + 1;
  localparam logic [REG_W-1:0] ONE_HI = REG_W'(1) << (COORD_W + FRAC_BITS);
  localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;

  logic [REG_W-1:0] regs [NUM_REGS];
  mat_t             mat;
  logic             mac_valid, mac_vec;
  sums_t            sums;

  logic             v4;
  logic             neg4 [3];
  logic [ACC_W-1:0] nmag4 [3];
  logic [ACC_W-1:0] dmag4;
  div_tag_t         tag4 [3];

  logic              dv [3];
  logic              dneg [3];
  logic              dovf [3];
  logic [Q_BITS-1:0] dq [3];
  div_tag_t          dtag [3];
  logic [COORD_W-1:0] lane_val [3];
  logic              lane_sat [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= ONE_HI;
      regs[1] <= '0;
      regs[2] <= ONE_LO;
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= ONE_HI;
      regs[6] <= '0;
      regs[7] <= ONE_LO;
    end else if (wr_en && wr_index < REG_IDX_W'(NUM_REGS)) begin
      regs[wr_index[2:0]] <= wr_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = regs[2*r][REG_W-1:COORD_W];
      mat[r][1] = regs[2*r][COORD_W-1:0];
      mat[r][2] = regs[2*r+1][REG_W-1:COORD_W];
      mat[r][3] = regs[2*r+1][COORD_W-1:0];
    end
  end

  hpt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_item   (item),
    .mat       (mat),
    .out_valid (mac_valid),
    .out_vec   (mac_vec),
    .out_sums  (sums)
  );

  // divide prep: magnitudes, quotient sign, clamped undivided sums
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= mac_valid;
  end

  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] s, w;
    logic                    wz;
    w  = $signed(sums[3]);
    wz = (mac_vec == ACT_POINT) && (w == '0);
    dmag4 <= w[ACC_W-1] ? ACC_W'(-w) : w;
    for (int r = 0; r < 3; r++) begin
      s = $signed(sums[r]);
      neg4[r]  <= s[ACC_W-1] ^ w[ACC_W-1];
      nmag4[r] <= s[ACC_W-1] ? ACC_W'(-s) : s;
      tag4[r].wzero   <= wz;
      tag4[r].use_div <= (mac_vec == ACT_POINT) && !wz;
      if (s > OUT_MAX) begin
        tag4[r].byp_val <= OUT_MAX[COORD_W-1:0];
        tag4[r].byp_sat <= 1'b1;
      end else if (s < OUT_MIN) begin
        tag4[r].byp_val <= OUT_MIN[COORD_W-1:0];
        tag4[r].byp_sat <= 1'b1;
      end else begin
        tag4[r].byp_val <= s[COORD_W-1:0];
        tag4[r].byp_sat <= 1'b0;
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_lane
    hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v4),
      .in_neg    (neg4[r]),
      .in_num    (nmag4[r]),
      .in_den    (dmag4),
      .in_tag    (tag4[r]),
      .out_valid (dv[r]),
      .out_neg   (dneg[r]),
      .out_ovf   (dovf[r]),
      .out_q     (dq[r]),
      .out_tag   (dtag[r])
    );

    // sign and clamp of the quotient
    always_comb begin
      lane_val[r] = dtag[r].byp_val;
      lane_sat[r] = dtag[r].byp_sat;
      if (dtag[r].use_div) begin
        if (dneg[r]) begin
          if (dovf[r] || dq[r] > Q_BITS'(OUT_MAX + 1)) begin
            lane_val[r] = OUT_MIN[COORD_W-1:0];
            lane_sat[r] = 1'b1;
          end else begin
            lane_val[r] = COORD_W'(-dq[r][COORD_W-1:0]);
            lane_sat[r] = 1'b0;
          end
        end else begin
          if (dovf[r] || dq[r] > Q_BITS'(OUT_MAX)) begin
            lane_val[r] = OUT_MAX[COORD_W-1:0];
            lane_sat[r] = 1'b1;
          end else begin
            lane_val[r] = dq[r][COORD_W-1:0];
            lane_sat[r] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv[0];
  end

  always_ff @(posedge clk) begin
    result.x_out      <= lane_val[0];
    result.y_out      <= lane_val[1];
    result.z_out      <= lane_val[2];
    result.w_was_zero <= dtag[0].wzero;
    result.saturated  <= lane_sat[0] | lane_sat[1] | lane_sat[2];
  end

  // every result traces back to an item taken at the head of the pipeline
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, PIPE_DEPTH))
    else $error("result without a matching item");

  // the three divider lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (dv[0] == dv[1]) && (dv[1] == dv[2]))
    else $error("divider lanes out of step");

  // an item whose w is zero skips the divider on every lane
  a_wzero_bypass: assert property (@(posedge clk) disable iff (rst)
    dv[0] && dtag[0].wzero |-> !dtag[0].use_div && !dtag[1].use_div && !dtag[2].use_div)
    else $error("divide used with zero w");

endmodule
